// ===== hw/rtl/psa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_pkg
// Shared types and constants for the Atkin sieve block.
// ----------------------------------------------------------------------------
package psa_pkg;

  localparam int unsigned CfgW = 15;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_QUAD_INIT,
    ST_QUAD_RD,
    ST_QUAD_WR,
    ST_ELIM_RD,
    ST_ELIM_CHK,
    ST_ELIM_WR,
    ST_QUERY_RD,
    ST_QUERY_WAIT,
    ST_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic clr_start;   // load clear pointer at 2
    logic clr_step;    // write zero/seed at pointer, advance
    logic quad_start;  // x=1, y=1, form 0
    logic quad_rd;     // issue read for current candidate
    logic quad_wr;     // write toggled value if valid, advance
    logic elim_start;  // p = 5
    logic elim_rd;     // read flag of p
    logic elim_next_p; // advance p
    logic elim_load_m; // m = p*p
    logic elim_wr;     // clear m, m += sq
    logic query_rd;    // read flag of query number
    logic load_run;    // result register: run
    logic load_query;  // result register: query
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic quad_last;
    logic elim_p_done;  // p*p > limit
    logic elim_flag;    // flag of p read back
    logic elim_m_done;  // m + p*p > limit
  } sts_t;

endpackage

// ===== hw/rtl/prime_sieve_atkin_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_sieve_atkin_top
// Sieve of Atkin primality bitmap with run and query operations.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall carries operation_i and number_i. A run
// (operation 0) rebuilds the bitmap for 2..upper_limit, a query (operation 1)
// reads one flag. Each transfer yields one result on out_valid/out_stall
// with is_prime_o and ready_res_o.
// A query reads its flag on transfer, then passes ST_QUERY_RD and
// ST_QUERY_WAIT (which loads the result) to ST_OUT. A run clears 2..limit,
// passes setup state ST_QUAD_INIT, does a read and a write per x,y,form
// candidate (read-modify-write on the flag memory), then a read and a check
// per elimination base p and a write per cleared multiple of p^2, to ST_OUT.
// One item is in work at a time; the result register holds until the
// receiver drops out_stall, and no new input is taken meanwhile.
// Reset clears the limit to 2 and the done flag; the bitmap is not cleared
// and a query counts its flag only after a run has written it.
// cfg_we writes upper_limit; changing it clears the done flag, so later query results have ready_res low.
// ----------------------------------------------------------------------------
module prime_sieve_atkin_top
  import psa_pkg::*;
#(
  parameter int unsigned MAX_NUMBERS = 32768
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we,
  input  logic [CfgW-1:0] cfg_data,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            operation_i,
  input  logic [CfgW-1:0] number_i,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            is_prime_o,
  output logic            ready_res_o
);

  cmd_t cmd;
  sts_t sts;

  psa_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .op_i(operation_i),
    .out_stall, .out_valid, .sts_i(sts), .cmd_o(cmd)
  );

  psa_dp #(.MAX_NUMBERS(MAX_NUMBERS)) u_dp (
    .clk_i, .rst_ni, .cfg_we, .cfg_data, .number_i, .cmd_i(cmd), .sts_o(sts),
    .is_prime_o, .ready_res_o
  );

endmodule

// ===== hw/rtl/psa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_ctrl
// Sequencer for clear, quadratic toggle, square elimination and query.
// ----------------------------------------------------------------------------
module psa_ctrl
  import psa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid,
  output logic in_stall,
  input  logic op_i,
  input  logic out_stall,
  output logic out_valid,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid) state_d = op_i ? ST_QUERY_RD : ST_CLEAR;
      end
      ST_CLEAR:      if (sts_i.clr_last) state_d = ST_QUAD_INIT;
      ST_QUAD_INIT:  state_d = ST_QUAD_RD;
      ST_QUAD_RD:    state_d = ST_QUAD_WR;
      ST_QUAD_WR:    state_d = sts_i.quad_last ? ST_ELIM_RD : ST_QUAD_RD;
      ST_ELIM_RD:    state_d = sts_i.elim_p_done ? ST_OUT : ST_ELIM_CHK;
      ST_ELIM_CHK:   state_d = sts_i.elim_flag ? ST_ELIM_WR : ST_ELIM_RD;
      ST_ELIM_WR:    if (sts_i.elim_m_done) state_d = ST_ELIM_RD;
      ST_QUERY_RD:   state_d = ST_QUERY_WAIT;
      ST_QUERY_WAIT: state_d = ST_OUT;
      ST_OUT:        if (!out_stall) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o     = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (op_i) cmd_o.query_rd = 1'b1;
          else cmd_o.clr_start = 1'b1;
        end
      end
      ST_CLEAR:     begin
        cmd_o.clr_step = 1'b1;
        cmd_o.quad_start = sts_i.clr_last;
      end
      ST_QUAD_INIT: cmd_o.quad_start = 1'b0;
      ST_QUAD_RD:   cmd_o.quad_rd = 1'b1;
      ST_QUAD_WR: begin
        cmd_o.quad_wr = 1'b1;
        cmd_o.elim_start = sts_i.quad_last;
      end
      ST_ELIM_RD: begin
        cmd_o.elim_rd = 1'b1;
        cmd_o.load_run = sts_i.elim_p_done;
      end
      ST_ELIM_CHK: begin
        cmd_o.elim_load_m = sts_i.elim_flag;
        cmd_o.elim_next_p = ~sts_i.elim_flag;
      end
      ST_ELIM_WR: begin
        cmd_o.elim_wr = 1'b1;
        cmd_o.elim_next_p = sts_i.elim_m_done;
      end
      ST_QUERY_WAIT: cmd_o.load_query = 1'b1;
      ST_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/psa_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_dp
// Flag memory, loop counters and candidate generation for the sieve.
// ----------------------------------------------------------------------------
module psa_dp
  import psa_pkg::*;
#(
  parameter int unsigned MAX_NUMBERS = 32768
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we,
  input  logic [CfgW-1:0] cfg_data,
  input  logic [CfgW-1:0] number_i,
  input  cmd_t            cmd_i,
  output sts_t            sts_o,
  output logic            is_prime_o,
  output logic            ready_res_o
);

  localparam int unsigned AW = $clog2(MAX_NUMBERS);
  // arithmetic width: covers 4x^2+y^2 up to 5*limit and m+sq
  localparam int unsigned NW = CfgW + 4;
  // x and y stay below sqrt(2^CfgW) + 2
  localparam int unsigned XW = 8;

  // reduce a value below 60 modulo 12
  function automatic logic [3:0] mod12_small(input logic [5:0] v);
    logic [5:0] t;
    t = v;
    if (t >= 6'd48) t = t - 6'd48;
    else if (t >= 6'd36) t = t - 6'd36;
    else if (t >= 6'd24) t = t - 6'd24;
    else if (t >= 6'd12) t = t - 6'd12;
    return t[3:0];
  endfunction

  logic mem [MAX_NUMBERS];
  logic rd_q;

  logic [CfgW-1:0] limit_q;
  logic            done_q;
  logic [NW-1:0]   lim;

  always_comb begin
    if ({{(NW-CfgW){1'b0}}, limit_q} > NW'(MAX_NUMBERS - 1)) lim = NW'(MAX_NUMBERS - 1);
    else lim = {{(NW-CfgW){1'b0}}, limit_q};
  end

  logic [NW-1:0] ptr_q;
  logic [XW-1:0] x_q, y_q;
  logic [NW-1:0] xx_q, yy_q;
  logic [1:0]    form_q;
  logic [NW-1:0] cand_q;
  logic          cand_ok_q;
  logic [NW-1:0] p_q, pp_q, m_q;
  // residues mod 12 of x, y, x^2, y^2, tracked alongside the counters
  logic [3:0]    xm_q, ym_q, xxm_q, yym_q;

  // candidate for current x,y,form
  logic [NW-1:0] cand;
  logic          cand_ok;
  logic [3:0]    cand_mod;
  always_comb begin
    case (form_q)
      2'd0: begin
        cand     = (xx_q << 2) + yy_q;
        cand_mod = mod12_small({xxm_q, 2'b00} + {2'b00, yym_q});
      end
      2'd1: begin
        cand     = (xx_q << 1) + xx_q + yy_q;
        cand_mod = mod12_small({1'b0, xxm_q, 1'b0} + {2'b00, xxm_q} + {2'b00, yym_q});
      end
      default: begin
        cand     = (xx_q << 1) + xx_q - yy_q;
        cand_mod = mod12_small({1'b0, xxm_q, 1'b0} + {2'b00, xxm_q} + 6'd12
                               - {2'b00, yym_q});
      end
    endcase
    case (form_q)
      2'd0:    cand_ok = (cand_mod == 4'd1) || (cand_mod == 4'd5);
      2'd1:    cand_ok = (cand_mod == 4'd7);
      default: cand_ok = (x_q > y_q) && (cand_mod == 4'd11);
    endcase
    cand_ok = cand_ok && (cand <= lim);
  end

  logic [NW-1:0] xx_nx, yy_nx;
  assign xx_nx = xx_q + (NW'(x_q) << 1) + NW'(1);
  assign yy_nx = yy_q + (NW'(y_q) << 1) + NW'(1);

  logic [3:0] xm_nx, ym_nx, xxm_nx, yym_nx;
  assign xm_nx  = (xm_q == 4'd11) ? 4'd0 : xm_q + 4'd1;
  assign ym_nx  = (ym_q == 4'd11) ? 4'd0 : ym_q + 4'd1;
  assign xxm_nx = mod12_small({2'b00, xxm_q} + {1'b0, xm_q, 1'b0} + 6'd1);
  assign yym_nx = mod12_small({2'b00, yym_q} + {1'b0, ym_q, 1'b0} + 6'd1);

  always_comb begin
    sts_o.clr_last    = (ptr_q >= lim);
    sts_o.quad_last   = (form_q == 2'd2) && (yy_nx > lim) && (xx_nx > lim);
    sts_o.elim_p_done = (pp_q > lim);
    sts_o.elim_flag   = rd_q;
    sts_o.elim_m_done = (m_q + pp_q > lim);
  end

  // memory port
  logic          we;
  logic [AW-1:0] wa, ra;
  logic          wd, re;
  always_comb begin
    we = 1'b0; wa = AW'(ptr_q); wd = 1'b0;
    re = 1'b0; ra = AW'(cand_q);
    if (cmd_i.clr_step && lim >= NW'(2)) begin
      we = 1'b1;
      wd = (ptr_q == NW'(2)) || (ptr_q == NW'(3));
    end
    if (cmd_i.quad_rd) begin
      re = 1'b1; ra = AW'(cand);
    end
    if (cmd_i.quad_wr && cand_ok_q) begin
      we = 1'b1; wa = AW'(cand_q); wd = ~rd_q;
    end
    if (cmd_i.elim_rd) begin
      re = 1'b1; ra = AW'(p_q);
    end
    if (cmd_i.elim_wr) begin
      we = 1'b1; wa = AW'(m_q); wd = 1'b0;
    end
    if (cmd_i.query_rd) begin
      re = 1'b1; ra = AW'(number_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (re) rd_q <= mem[ra];
  end

  logic [CfgW-1:0] qnum_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.query_rd) qnum_q <= number_i;
    if (cmd_i.clr_start) ptr_q <= NW'(2);
    else if (cmd_i.clr_step) ptr_q <= ptr_q + NW'(1);
    if (cmd_i.quad_start) begin
      x_q <= XW'(1); y_q <= XW'(1); xx_q <= NW'(1); yy_q <= NW'(1); form_q <= 2'd0;
      xm_q <= 4'd1; ym_q <= 4'd1; xxm_q <= 4'd1; yym_q <= 4'd1;
    end else if (cmd_i.quad_wr) begin
      if (form_q != 2'd2) form_q <= form_q + 2'd1;
      else begin
        form_q <= 2'd0;
        if (yy_nx <= lim) begin
          y_q <= y_q + XW'(1); yy_q <= yy_nx;
          ym_q <= ym_nx; yym_q <= yym_nx;
        end else begin
          y_q <= XW'(1); yy_q <= NW'(1);
          ym_q <= 4'd1; yym_q <= 4'd1;
          x_q <= x_q + XW'(1); xx_q <= xx_nx;
          xm_q <= xm_nx; xxm_q <= xxm_nx;
        end
      end
    end
    if (cmd_i.quad_rd) begin
      cand_q <= cand; cand_ok_q <= cand_ok;
    end
    if (cmd_i.elim_start) begin
      p_q <= NW'(5); pp_q <= NW'(25);
    end else if (cmd_i.elim_next_p) begin
      p_q <= p_q + NW'(1); pp_q <= pp_q + (p_q << 1) + NW'(1);
    end
    if (cmd_i.elim_load_m) m_q <= pp_q;
    else if (cmd_i.elim_wr) m_q <= m_q + pp_q;
  end

  // x loop ends when xx exceeds lim; guarded by quad_last using xx_nx
  logic qv;
  assign qv = done_q && (qnum_q >= CfgW'(2)) && ({{(NW-CfgW){1'b0}}, qnum_q} <= lim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= CfgW'(2); done_q <= 1'b0; is_prime_o <= 1'b0; ready_res_o <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_data != limit_q) done_q <= 1'b0;
        limit_q <= cfg_data;
      end
      if (cmd_i.load_run) begin
        done_q <= 1'b1; is_prime_o <= 1'b0; ready_res_o <= 1'b1;
      end
      if (cmd_i.load_query) begin
        is_prime_o <= qv & rd_q; ready_res_o <= done_q;
      end
    end
  end

endmodule
